FILE: rtl/gclp_pkg.sv
// ----------------------------------------------------------------------------
// gclp_pkg
// Types, character codes and helpers shared by the G-code line parser.
// ----------------------------------------------------------------------------
package gclp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EXP   = 8'h65;

  localparam int MANT_W = 60;
  localparam int MAG_W  = 48;
  localparam logic [MANT_W-1:0] MANT_SAT = '1;

  typedef enum logic [1:0] {
    PH_CLASS,
    PH_NUMBER,
    PH_LETTER,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_FIN
  } bk_state_t;

  // One finished token as handed from the front to the scaler.
  typedef struct packed {
    logic [7:0]        letter;
    logic              neg;
    logic [MANT_W-1:0] mant;
    logic [4:0]        frac;
    logic              exp_neg;
    logic [5:0]        exp;
    logic [2:0]        index;
    logic              last;
    logic              err;
    logic              ovf;
  } token_t;

  // 10^n, used at elaboration only.
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < n; i++) begin
      v = v * 64'd10;
    end
    return v;
  endfunction

endpackage

FILE: rtl/gcode_line_token_parser.sv
// ----------------------------------------------------------------------------
// gcode_line_token_parser
// Splits a NUL-terminated G-code line into tokens and converts each number
// to signed fixed point with FRAC_BITS fraction bits, saturated to 48 bits.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser / tlast
//  in_     | in  | [7:0] ch                           | -
//  out_    | out | [7:0] letter [55:8] value [58:56] idx | tuser[0] format_error,
//          |     |                                    | tuser[1] param_overflow,
//          |     |                                    | tlast line_end
//
//  The classifier takes one character per cycle while the token queue
//  (two entries) has room. A zero or saturated value needs no scaling; a
//  positive power p takes up to p multiplies by ten, and a negative power
//  takes |p| divide-by-ten sweeps over all 4-bit digits of the accumulator,
//  one 4-bit digit of the sweep per cycle. Reset (rst_n low, sync)
//  clears all control state; no clearing pass. A stalled output holds the
//  result register and backs up into the queue, then into in_tready.
// ----------------------------------------------------------------------------
module gcode_line_token_parser import gclp_pkg::*; #(
  parameter int MAX_PARAMS = 6,
  parameter int FRAC_BITS  = 16,
  parameter int MAX_DIGITS = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] token_letter, [55:8] token_value,
                                  // [58:56] token_index, rest zero
  output logic [1:0]  out_tuser,  // [0] format_error, [1] param_overflow
  output logic        out_tlast   // line_end
);

  logic             q_full, q_valid, q_push, q_pop;
  token_t           q_in, q_head;
  logic [7:0]       r_letter;
  logic [MAG_W-1:0] r_value;
  logic [2:0]       r_index;
  logic             r_last, r_err, r_ovf;

  // front: accept characters, build token descriptors
  gclp_front #(
    .MAX_PARAMS(MAX_PARAMS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ch_valid (in_tvalid),
    .ch       (in_tdata),
    .ch_ready (in_tready),
    .q_full   (q_full),
    .push     (q_push),
    .push_tok (q_in)
  );

  // decouple character intake from the multi-cycle scaler
  gclp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // back: scale by the power of ten, saturate, hold for the sink
  gclp_scale #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_letter (r_letter),
    .res_value  (r_value),
    .res_index  (r_index),
    .res_last   (r_last),
    .res_err    (r_err),
    .res_ovf    (r_ovf)
  );

  assign out_tdata = {5'd0, r_index, r_value, r_letter};
  assign out_tuser = {r_ovf, r_err};
  assign out_tlast = r_last;

  // a closing token (letter NUL) only ever ends a line
  a_nul_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:0] == 8'h00 |-> out_tlast)
    else $error("closing token without line_end");

  // a closing token carries a zero value
  a_nul_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:0] == 8'h00 |-> out_tdata[55:8] == '0)
    else $error("closing token with nonzero value");

  // token index never exceeds the parameter limit
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[58:56] <= 3'(MAX_PARAMS))
    else $error("token index beyond limit");

  // the queue is not popped while it is empty
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty token queue");

endmodule

FILE: rtl/gclp_front.sv
// ----------------------------------------------------------------------------
// gclp_front
// Character classifier: tracks the line phase, accumulates mantissa and
// exponent digits, and pushes one token descriptor per finished token.
// ----------------------------------------------------------------------------
module gclp_front import gclp_pkg::*; #(
  parameter int MAX_PARAMS = 6,
  parameter int MAX_DIGITS = 18
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ch_valid,
  input  logic [7:0] ch,
  output logic       ch_ready,
  input  logic       q_full,
  output logic       push,
  output token_t     push_tok
);

  localparam logic [63:0] DIG_LIMIT = pow10(MAX_DIGITS);

  phase_t            phase_r, phase_nxt;
  logic [7:0]        letter_r, letter_nxt;
  logic              neg_r, neg_nxt;
  logic [MANT_W-1:0] mant_r, mant_nxt;
  logic [4:0]        frac_r, frac_nxt;
  logic              point_r, point_nxt;
  logic              in_exp_r, in_exp_nxt;
  logic              exp_neg_r, exp_neg_nxt;
  logic [5:0]        exp_r, exp_nxt;
  logic [2:0]        count_r, count_nxt;
  logic              err_r, err_nxt;
  logic              ovf_r, ovf_nxt;
  logic              seg_r, seg_nxt;
  logic              exp_point_r, exp_point_nxt;

  logic        take;
  logic        emit;
  logic        emit_end;
  logic        emit_zero;
  logic        err_now;
  logic [3:0]  dig;
  logic [63:0] m_ext;
  logic [9:0]  e_ext;

  assign ch_ready = !q_full;
  assign take     = ch_valid && ch_ready;
  assign dig      = ch[3:0];
  assign m_ext    = (64'(mant_r) << 3) + (64'(mant_r) << 1) + 64'(dig);
  assign e_ext    = (10'(exp_r) << 3) + (10'(exp_r) << 1) + 10'(dig);

  always_comb begin
    phase_nxt     = phase_r;
    letter_nxt    = letter_r;
    neg_nxt       = neg_r;
    mant_nxt      = mant_r;
    frac_nxt      = frac_r;
    point_nxt     = point_r;
    in_exp_nxt    = in_exp_r;
    exp_neg_nxt   = exp_neg_r;
    exp_nxt       = exp_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    seg_nxt       = seg_r;
    exp_point_nxt = exp_point_r;
    err_now       = 1'b0;
    emit          = 1'b0;
    emit_end      = 1'b0;
    emit_zero     = 1'b0;
    if (take) begin
      case (phase_r)
        PH_CLASS: begin
          if (ch != CH_NUL) begin
            letter_nxt = ch;
            phase_nxt  = PH_NUMBER;
          end
        end
        PH_NUMBER: begin
          if (ch == CH_NUL) begin
            emit     = 1'b1;
            emit_end = 1'b1;
          end else if (ch == CH_SPACE) begin
            emit      = 1'b1;
            phase_nxt = PH_LETTER;
          end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            seg_nxt = 1'b1;
            if (in_exp_r) begin
              if (!exp_point_r) begin
                exp_nxt = (e_ext > 10'd63) ? 6'd63 : e_ext[5:0];
              end
            end else if (64'(mant_r) < DIG_LIMIT) begin
              if (m_ext < DIG_LIMIT) begin
                mant_nxt = m_ext[MANT_W-1:0];
                if (point_r) begin
                  frac_nxt = frac_r + 5'd1;
                end
              end else if (!point_r) begin
                mant_nxt = MANT_SAT;
              end
            end
          end else if (ch == CH_MINUS) begin
            if (seg_r) begin
              err_now = 1'b1;
            end else begin
              seg_nxt = 1'b1;
              if (in_exp_r) begin
                exp_neg_nxt = 1'b1;
              end else begin
                neg_nxt = 1'b1;
              end
            end
          end else if (ch == CH_POINT) begin
            if (in_exp_r) begin
              if (exp_point_r) begin
                err_now = 1'b1;
              end
              exp_point_nxt = 1'b1;
            end else if (point_r) begin
              err_now = 1'b1;
            end else begin
              point_nxt = 1'b1;
              seg_nxt   = 1'b1;
            end
          end else if (ch == CH_EXP) begin
            if (in_exp_r) begin
              err_now = 1'b1;
            end else begin
              in_exp_nxt = 1'b1;
              seg_nxt    = 1'b0;
            end
          end else begin
            err_now = 1'b1;
          end
        end
        PH_LETTER: begin
          if (ch == CH_NUL) begin
            err_now   = 1'b1;
            emit      = 1'b1;
            emit_end  = 1'b1;
            emit_zero = 1'b1;
          end else if (ch == CH_SPACE) begin
            err_now = 1'b1;
          end else if (count_r >= 3'(MAX_PARAMS)) begin
            ovf_nxt   = 1'b1;
            phase_nxt = PH_SKIP;
          end else begin
            count_nxt  = count_r + 3'd1;
            letter_nxt = ch;
            phase_nxt  = PH_NUMBER;
          end
        end
        PH_SKIP: begin
          if (ch == CH_NUL) begin
            emit      = 1'b1;
            emit_end  = 1'b1;
            emit_zero = 1'b1;
          end else if (ch == CH_SPACE) begin
            phase_nxt = PH_LETTER;
          end
        end
        default: begin
          phase_nxt = PH_CLASS;
        end
      endcase
      // a new token or a finished one starts from a clean number
      if (emit || phase_nxt == PH_NUMBER && phase_r != PH_NUMBER) begin
        neg_nxt       = 1'b0;
        mant_nxt      = '0;
        frac_nxt      = '0;
        point_nxt     = 1'b0;
        in_exp_nxt    = 1'b0;
        exp_neg_nxt   = 1'b0;
        exp_nxt       = '0;
        seg_nxt       = 1'b0;
        exp_point_nxt = 1'b0;
      end
      if (emit_end) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        phase_nxt = PH_CLASS;
      end
    end
    err_nxt = emit ? 1'b0 : (err_r | err_now);
  end

  always_comb begin
    push              = emit;
    push_tok.letter   = emit_zero ? CH_NUL : letter_r;
    push_tok.neg      = neg_r;
    push_tok.mant     = emit_zero ? '0 : mant_r;
    push_tok.frac     = frac_r;
    push_tok.exp_neg  = exp_neg_r;
    push_tok.exp      = exp_r;
    push_tok.index    = count_r;
    push_tok.last     = emit_end;
    push_tok.err      = err_r | err_now;
    push_tok.ovf      = ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CLASS;
      letter_r    <= '0;
      neg_r       <= 1'b0;
      mant_r      <= '0;
      frac_r      <= '0;
      point_r     <= 1'b0;
      in_exp_r    <= 1'b0;
      exp_neg_r   <= 1'b0;
      exp_r       <= '0;
      count_r     <= '0;
      err_r       <= 1'b0;
      ovf_r       <= 1'b0;
      seg_r       <= 1'b0;
      exp_point_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      letter_r    <= letter_nxt;
      neg_r       <= neg_nxt;
      mant_r      <= mant_nxt;
      frac_r      <= frac_nxt;
      point_r     <= point_nxt;
      in_exp_r    <= in_exp_nxt;
      exp_neg_r   <= exp_neg_nxt;
      exp_r       <= exp_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      ovf_r       <= ovf_nxt;
      seg_r       <= seg_nxt;
      exp_point_r <= exp_point_nxt;
    end
  end

endmodule

FILE: rtl/gclp_queue.sv
// ----------------------------------------------------------------------------
// gclp_queue
// Two-entry token queue between the classifier and the scaler.
// ----------------------------------------------------------------------------
module gclp_queue import gclp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t push_tok,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output token_t head
);

  token_t     mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/gclp_scale.sv
// ----------------------------------------------------------------------------
// gclp_scale
// Scales a token mantissa by its power of ten into signed fixed point,
// one multiply by ten per cycle or one divide by ten per word sweep, and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module gclp_scale import gclp_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_DIGITS = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  token_t             q_head,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         res_letter,
  output logic [MAG_W-1:0]   res_value,
  output logic [2:0]         res_index,
  output logic               res_last,
  output logic               res_err,
  output logic               res_ovf
);

  localparam int ACC_W = ((MANT_W + FRAC_BITS + 3) / 4) * 4;
  localparam int NCH   = ACC_W / 4;
  localparam int CH_W  = $clog2(NCH);
  localparam logic [63:0]      DIG_LIMIT = pow10(MAX_DIGITS);
  localparam logic [ACC_W-1:0] CAP_ACC   = ACC_W'(64'd1 << (MAG_W - 1));
  localparam logic [ACC_W-1:0] CAP_PRE   = ACC_W'(64'd1 << (MAG_W - 1 - FRAC_BITS));
  localparam logic [MAG_W-1:0] CAP       = MAG_W'(64'd1 << (MAG_W - 1));

  bk_state_t        state_r, state_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [CH_W-1:0]  chunk_r, chunk_nxt;
  logic [3:0]       rem_r, rem_nxt;
  logic             last_div_r, last_div_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [7:0]       letter_r;
  logic             neg_r;
  logic [2:0]       index_r;
  logic             end_r, err_r, ovf_r;

  logic             ov_r, ov_nxt;
  logic [MAG_W-1:0] val_r, val_nxt;
  logic [7:0]       oletter_r;
  logic [2:0]       oindex_r;
  logic             oend_r, oerr_r, oovf_r;
  logic             load_out;

  logic signed [7:0] p;
  logic [7:0]        p_neg;
  logic [6:0]        dcnt;
  logic [4:0]        r;
  logic [3:0]        q;
  logic [ACC_W-1:0]  quot;
  logic [MAG_W-1:0]  mag_c;

  assign p = (q_head.exp_neg ? -$signed({2'b00, q_head.exp}) : $signed({2'b00, q_head.exp}))
             - $signed({3'b000, q_head.frac});
  assign p_neg = 8'(-p);
  assign dcnt  = p_neg[6:0] - 7'd1;

  // four restoring steps of long division by ten
  always_comb begin
    r = {1'b0, rem_r};
    q = '0;
    for (int i = 0; i < 4; i++) begin
      r = {r[3:0], acc_r[ACC_W-1-i]};
      if (r >= 5'd10) begin
        r       = r - 5'd10;
        q[3-i]  = 1'b1;
      end
    end
    quot = {acc_r[ACC_W-5:0], q};
  end

  assign mag_c   = (!neg_r && mag_r == CAP) ? CAP - MAG_W'(1) : mag_r;
  assign load_out = (state_r == BK_FIN) && (!ov_r || res_ready);
  assign q_pop   = (state_r == BK_IDLE) && q_valid;

  always_comb begin
    state_nxt    = state_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    chunk_nxt    = chunk_r;
    rem_nxt      = rem_r;
    last_div_nxt = last_div_r;
    mag_nxt      = mag_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          chunk_nxt = '0;
          rem_nxt   = '0;
          if (64'(q_head.mant) >= DIG_LIMIT) begin
            mag_nxt   = CAP;
            state_nxt = BK_FIN;
          end else if (q_head.mant == '0) begin
            mag_nxt   = '0;
            state_nxt = BK_FIN;
          end else if (!p[7]) begin
            acc_nxt   = ACC_W'(q_head.mant);
            cnt_nxt   = p[6:0];
            state_nxt = BK_MUL;
          end else begin
            acc_nxt      = (ACC_W'(q_head.mant) << FRAC_BITS)
                           + ((dcnt == 7'd0) ? ACC_W'(5) : ACC_W'(0));
            cnt_nxt      = dcnt;
            last_div_nxt = (dcnt == 7'd0);
            state_nxt    = BK_DIV;
          end
        end
      end
      BK_MUL: begin
        if (cnt_r == 7'd0 || acc_r > CAP_ACC) begin
          mag_nxt   = (acc_r > CAP_PRE) ? CAP : MAG_W'(acc_r << FRAC_BITS);
          state_nxt = BK_FIN;
        end else begin
          acc_nxt = (acc_r << 3) + (acc_r << 1);
          cnt_nxt = cnt_r - 7'd1;
        end
      end
      BK_DIV: begin
        acc_nxt   = quot;
        rem_nxt   = r[3:0];
        chunk_nxt = chunk_r + CH_W'(1);
        if (chunk_r == CH_W'(NCH - 1)) begin
          chunk_nxt = '0;
          rem_nxt   = '0;
          if (last_div_r) begin
            mag_nxt   = (quot > CAP_ACC) ? CAP : quot[MAG_W-1:0];
            state_nxt = BK_FIN;
          end else begin
            cnt_nxt = cnt_r - 7'd1;
            if (cnt_r == 7'd1) begin
              acc_nxt      = quot + ACC_W'(5);
              last_div_nxt = 1'b1;
            end
          end
        end
      end
      BK_FIN: begin
        if (load_out) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt  = ov_r && !res_ready;
    val_nxt = val_r;
    if (load_out) begin
      ov_nxt  = 1'b1;
      val_nxt = neg_r ? MAG_W'(-mag_c) : mag_c;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      letter_r <= q_head.letter;
      neg_r    <= q_head.neg;
      index_r  <= q_head.index;
      end_r    <= q_head.last;
      err_r    <= q_head.err;
      ovf_r    <= q_head.ovf;
    end
    if (load_out) begin
      oletter_r <= letter_r;
      oindex_r  <= index_r;
      oend_r    <= end_r;
      oerr_r    <= err_r;
      oovf_r    <= ovf_r;
    end
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    last_div_r <= last_div_nxt;
    mag_r      <= mag_nxt;
    val_r      <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      chunk_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chunk_r <= chunk_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign res_valid  = ov_r;
  assign res_letter = oletter_r;
  assign res_value  = val_r;
  assign res_index  = oindex_r;
  assign res_last   = oend_r;
  assign res_err    = oerr_r;
  assign res_ovf    = oovf_r;

endmodule
